// ===== hdl/mcbpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mcbpq_pkg
// Shared types and result codes for the multi-class bounded priority queue.
// ----------------------------------------------------------------------------
package mcbpq_pkg;

   localparam int CLASS_W = 5;
   localparam int REQ_ID_W = 16;
   localparam int CODE_W = 3;

   localparam logic FUNC_ADD = 1'b0;
   localparam logic FUNC_TAKE = 1'b1;

   localparam logic [CODE_W-1:0] CODE_ADDED = 3'd0;
   localparam logic [CODE_W-1:0] CODE_FULL = 3'd1;
   localparam logic [CODE_W-1:0] CODE_BAD_CLASS = 3'd2;
   localparam logic [CODE_W-1:0] CODE_SERVED = 3'd3;
   localparam logic [CODE_W-1:0] CODE_EMPTY = 3'd4;

   // classified command word handed from front to back
   typedef struct packed {
      logic                func;
      logic                bad_class;
      logic [CLASS_W-1:0]  class_index;
      logic [REQ_ID_W-1:0] entry_id;
      logic                urgent;
   } cmd_type;

endpackage

// ===== hdl/mcbpq_front.sv =====
// ----------------------------------------------------------------------------
// mcbpq_front
// Accepts request words, checks the class range and holds them in a
// two-entry command queue for the back end.
// ----------------------------------------------------------------------------
module mcbpq_front
   import mcbpq_pkg::*;
#(
   parameter int NUM_CLASSES = 20
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_func,
   input  logic [CLASS_W-1:0]  req_class_index,
   input  logic [REQ_ID_W-1:0] req_entry_id,
   input  logic                req_urgent,
   input  logic                cmd_pop,
   output logic                cmd_valid,
   output cmd_type             cmd_word
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       push;
   logic       do_pop;
   cmd_type    new_cmd;

   assign busy = (count_ff == 2'd2);
   assign push = start && !busy;
   assign cmd_valid = (count_ff != 2'd0);
   assign do_pop = cmd_pop && cmd_valid;
   assign cmd_word = slot_ff[rd_ptr_ff];

   always_comb begin
      new_cmd.func = req_func;
      new_cmd.bad_class = (req_class_index == '0) ||
                          ({1'b0, req_class_index} > (CLASS_W + 1)'(NUM_CLASSES));
      new_cmd.class_index = req_class_index;
      new_cmd.entry_id = req_entry_id;
      new_cmd.urgent = req_urgent;
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/mcbpq_back.sv =====
// ----------------------------------------------------------------------------
// mcbpq_back
// Executes queued commands against per-class ring buffers held in one
// entry memory, and drives the one-cycle result strobe.
// ----------------------------------------------------------------------------
module mcbpq_back
   import mcbpq_pkg::*;
#(
   parameter int NUM_CLASSES = 20,
   parameter int QUEUE_DEPTH = 5,
   parameter int ID_WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  cmd_type             cmd_word,
   output logic                cmd_pop,
   output logic                rsp_strobe,
   output logic [CODE_W-1:0]   rsp_result_code,
   output logic [REQ_ID_W-1:0] rsp_served_id
);

   localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = ((SLOT_W > CNT_W) ? SLOT_W : CNT_W) + 1;
   localparam int MEM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
   localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOOKUP = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;
   localparam logic [1:0] ST_READ = 2'd3;

   logic [ID_WIDTH-1:0] mem [MEM_DEPTH];
   logic [ID_WIDTH-1:0] rd_data_ff;

   logic [CNT_W-1:0]  cnt_ff [NUM_CLASSES];
   logic [SLOT_W-1:0] head_ff [NUM_CLASSES];

   logic [1:0]        state_ff;
   logic [1:0]        state_in;
   cmd_type           cmd_ff;
   logic [CLS_W-1:0]  q_ff;
   logic [CLS_W-1:0]  q_in;
   logic [ADDR_W-1:0] base_ff;
   logic [ADDR_W-1:0] base_in;
   logic [CNT_W-1:0]  n_ff;
   logic [SLOT_W-1:0] h_ff;

   logic                rsp_strobe_ff;
   logic                rsp_strobe_in;
   logic [CODE_W-1:0]   rsp_code_ff;
   logic [CODE_W-1:0]   rsp_code_in;
   logic [REQ_ID_W-1:0] rsp_id_ff;
   logic [REQ_ID_W-1:0] rsp_id_in;

   logic                mem_we;
   logic                mem_re;
   logic [SLOT_W-1:0]   slot;
   logic [ADDR_W-1:0]   mem_addr;
   logic                tbl_we;
   logic [CNT_W-1:0]    cnt_wdata;
   logic [SLOT_W-1:0]   head_wdata;
   logic [SUM_W-1:0]    tail_sum;
   logic [SUM_W-1:0]    head_inc;
   logic [SLOT_W-1:0]   tail_slot;
   logic [SLOT_W-1:0]   head_next;
   logic [SLOT_W-1:0]   head_prev;
   logic                is_full;
   logic                is_empty;

   assign cmd_pop = (state_ff == ST_IDLE) && cmd_valid;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_result_code = rsp_code_ff;
   assign rsp_served_id = rsp_id_ff;

   // bad classes map to queue 0 so table reads stay in range
   always_comb begin
      if (cmd_word.bad_class) begin
         q_in = '0;
      end else begin
         q_in = CLS_W'(cmd_word.class_index - CLASS_W'(1));
      end
      base_in = ADDR_W'(q_in * QUEUE_DEPTH);
   end

   // ring buffer slot arithmetic
   always_comb begin
      tail_sum = SUM_W'(h_ff) + SUM_W'(n_ff);
      tail_slot = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                  SLOT_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : SLOT_W'(tail_sum);
      head_inc = SUM_W'(h_ff) + SUM_W'(1);
      head_next = (head_inc == SUM_W'(QUEUE_DEPTH)) ? '0 : SLOT_W'(head_inc);
      head_prev = (h_ff == '0) ? SLOT_W'(QUEUE_DEPTH - 1) : SLOT_W'(h_ff - SLOT_W'(1));
      is_full = (n_ff == CNT_W'(QUEUE_DEPTH));
      is_empty = (n_ff == '0);
   end

   always_comb begin
      state_in = state_ff;
      mem_we = 1'b0;
      mem_re = 1'b0;
      slot = h_ff;
      tbl_we = 1'b0;
      cnt_wdata = n_ff;
      head_wdata = h_ff;
      rsp_strobe_in = 1'b0;
      rsp_code_in = rsp_code_ff;
      rsp_id_in = rsp_id_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            rsp_id_in = '0;
            if (cmd_ff.bad_class) begin
               rsp_strobe_in = 1'b1;
               rsp_code_in = CODE_BAD_CLASS;
            end else if (cmd_ff.func == FUNC_ADD) begin
               rsp_strobe_in = 1'b1;
               if (is_full) begin
                  rsp_code_in = CODE_FULL;
               end else begin
                  rsp_code_in = CODE_ADDED;
                  mem_we = 1'b1;
                  tbl_we = 1'b1;
                  cnt_wdata = n_ff + CNT_W'(1);
                  if (cmd_ff.urgent) begin
                     slot = head_prev;
                     head_wdata = head_prev;
                  end else begin
                     slot = tail_slot;
                  end
               end
            end else if (is_empty) begin
               rsp_strobe_in = 1'b1;
               rsp_code_in = CODE_EMPTY;
            end else begin
               mem_re = 1'b1;
               tbl_we = 1'b1;
               cnt_wdata = n_ff - CNT_W'(1);
               head_wdata = head_next;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_code_in = CODE_SERVED;
            rsp_id_in = REQ_ID_W'(rd_data_ff);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      mem_addr = base_ff + ADDR_W'(slot);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= ID_WIDTH'(cmd_ff.entry_id);
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff <= cmd_word;
         q_ff <= q_in;
         base_ff <= base_in;
      end
      if (state_ff == ST_LOOKUP) begin
         n_ff <= cnt_ff[q_ff];
         h_ff <= head_ff[q_ff];
      end
      rsp_code_ff <= rsp_code_in;
      rsp_id_ff <= rsp_id_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            cnt_ff[i] <= '0;
            head_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (tbl_we) begin
            cnt_ff[q_ff] <= cnt_wdata;
            head_ff[q_ff] <= head_wdata;
         end
      end
   end

endmodule

// ===== hdl/multi_class_bounded_priority_queue.sv =====
// ----------------------------------------------------------------------------
// multi_class_bounded_priority_queue
// NUM_CLASSES bounded queues with regular tail append and urgent head insert.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low. The front end
// buffers up to two classified words, so busy rises only when both are
// waiting. The back end handles one word at a time, stepping through table
// lookup, execute and result; a take that serves an entry adds a registered
// read of the entry memory, which supplies the id. Each queue is a ring
// buffer with a head pointer, so no entry ever moves. Every word gives one
// result, in order, on rsp_* for one cycle with rsp_strobe high; the
// receiver cannot stall it. Reset clears all queue counts at once.
module multi_class_bounded_priority_queue
   import mcbpq_pkg::*;
#(
   parameter int NUM_CLASSES = 20,
   parameter int QUEUE_DEPTH = 5,
   parameter int ID_WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_func,
   input  logic [CLASS_W-1:0]  req_class_index,
   input  logic [REQ_ID_W-1:0] req_entry_id,
   input  logic                req_urgent,
   output logic                rsp_strobe,
   output logic [CODE_W-1:0]   rsp_result_code,
   output logic [REQ_ID_W-1:0] rsp_served_id
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_word;

   mcbpq_front #(
      .NUM_CLASSES(NUM_CLASSES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_func(req_func),
      .req_class_index(req_class_index),
      .req_entry_id(req_entry_id),
      .req_urgent(req_urgent),
      .cmd_pop(cmd_pop),
      .cmd_valid(cmd_valid),
      .cmd_word(cmd_word)
   );

   mcbpq_back #(
      .NUM_CLASSES(NUM_CLASSES),
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .ID_WIDTH(ID_WIDTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cmd_valid(cmd_valid),
      .cmd_word(cmd_word),
      .cmd_pop(cmd_pop),
      .rsp_strobe(rsp_strobe),
      .rsp_result_code(rsp_result_code),
      .rsp_served_id(rsp_served_id)
   );

endmodule
